// File: src/indexed_ordered_list_engine_core_macros.svh
// Assertion macros used by the list engine RTL.
`ifndef INDEXED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_ORDERED_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define IOLE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("list engine check failed");
// The consequent must hold in the cycle after the antecedent.
`define IOLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("list engine check failed");
`else
`define IOLE_ASSERT_SAME(label, clk, rst, ante, cons)
`define IOLE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/iole_pkg.sv
// Shared codes, types and constants of the indexed ordered list engine.
package iole_pkg;

   localparam int DEFAULT_CAPACITY = 64;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 6;
   localparam int COUNT_W  = 7;

   localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FIND   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_MINMAX = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef enum logic [1:0] {
      SHIFT_NONE,
      SHIFT_UP,
      SHIFT_DOWN
   } shift_op_type;

   // Command broadcast to every cell; op is a one-cycle pulse.
   typedef struct packed {
      shift_op_type                op;
      logic [POS_W-1:0]            position;
      logic signed [DATA_W-1:0]    value;
   } cell_cmd_type;

   // Partial result handed from cell to cell during a sweep.
   typedef struct packed {
      logic                        valid;
      logic                        found;
      logic [FIDX_W-1:0]           found_index;
      logic signed [DATA_W-1:0]    read_value;
      logic signed [DATA_W-1:0]    minimum;
      logic signed [DATA_W-1:0]    maximum;
   } sweep_type;

endpackage

// File: src/iole_cell.sv
// One list cell: holds one entry and folds it into the passing sweep word.
module iole_cell #(
   parameter int INDEX    = 0,
   parameter int CW       = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iole_pkg::cell_cmd_type              cmd,
   input  logic [CW-1:0]                       count_i,
   input  logic signed [iole_pkg::DATA_W-1:0]  left_entry_i,
   input  logic signed [iole_pkg::DATA_W-1:0]  right_entry_i,
   output logic signed [iole_pkg::DATA_W-1:0]  entry_o,
   input  iole_pkg::sweep_type                 sweep_i,
   output iole_pkg::sweep_type                 sweep_o
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [iole_pkg::DATA_W-1:0] entry_ff, entry_in;
   logic                               sweep_valid_ff;
   iole_pkg::sweep_type                sweep_data_ff, sweep_in;
   logic [CW-1:0]                      pos_ext;

   assign pos_ext = CW'(cmd.position);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         iole_pkg::SHIFT_UP: begin
            if (IDX == pos_ext) begin
               entry_in = cmd.value;
            end else if (IDX > pos_ext) begin
               entry_in = left_entry_i;
            end
         end
         iole_pkg::SHIFT_DOWN: begin
            if (IDX >= pos_ext) begin
               entry_in = right_entry_i;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Only cells below the count take part; the others pass the word on.
   always_comb begin
      sweep_in = sweep_i;
      if (IDX < count_i) begin
         if (IDX == pos_ext) begin
            sweep_in.read_value = entry_ff;
         end
         if (!sweep_i.found && (entry_ff == cmd.value)) begin
            sweep_in.found       = 1'b1;
            sweep_in.found_index = iole_pkg::FIDX_W'(INDEX);
         end
         if (INDEX == 0) begin
            sweep_in.minimum = entry_ff;
            sweep_in.maximum = entry_ff;
         end else begin
            if (entry_ff < sweep_i.minimum) begin
               sweep_in.minimum = entry_ff;
            end
            if (entry_ff > sweep_i.maximum) begin
               sweep_in.maximum = entry_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (sweep_i.valid) begin
         sweep_data_ff <= sweep_in;
      end
      if (reset) begin
         sweep_valid_ff <= 1'b0;
      end else begin
         sweep_valid_ff <= sweep_i.valid;
      end
   end

   assign entry_o = entry_ff;

   always_comb begin
      sweep_o       = sweep_data_ff;
      sweep_o.valid = sweep_valid_ff;
   end

endmodule

// File: src/indexed_ordered_list_engine_core.sv
// Top level of the indexed ordered list engine: request control and the cell chain.
// A taken request is registered, its sweep word passes each cell register in turn, and
// the result loads the response register once it is free; only then is a new request taken.
// A taken response may still wait on rsp_tready while the next request is accepted.
// Reset clears the entry count, the control state and the response valid flag.
// Entry storage has no reset; entries past the count are never observed.
`include "indexed_ordered_list_engine_core_macros.svh"

module indexed_ordered_list_engine_core #(
   parameter int CAPACITY = iole_pkg::DEFAULT_CAPACITY
) (
   input  logic          clock,
   input  logic          reset,
   // Request channel.
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [39:0]   req_tdata,   // position[6:0], value[38:7], zero fill[39]
   input  logic [2:0]    req_tuser,   // kind[2:0]
   // Response channel.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata    // status[1:0], read_value[33:2], found[34],
                                      // found_index[40:35], minimum[72:41],
                                      // maximum[104:73], count[111:105]
);

   // Count width holds the capacity itself; CW is wide enough for both the
   // count and the 7-bit position field so that comparisons are exact.
   localparam int CNTW = $clog2(CAPACITY + 1);
   localparam int CW   = (CNTW > iole_pkg::POS_W) ? CNTW : iole_pkg::POS_W;
   localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type                               state_ff;
   logic [CNTW-1:0]                         count_ff;
   logic [CNTW-1:0]                         count_in;
   logic [iole_pkg::KIND_W-1:0]             kind_ff;
   logic [iole_pkg::STATUS_W-1:0]           status_ff;
   logic [iole_pkg::STATUS_W-1:0]           status_in;
   iole_pkg::shift_op_type                  op_ff;
   iole_pkg::shift_op_type                  op_in;
   logic [iole_pkg::POS_W-1:0]              pos_ff;
   logic signed [iole_pkg::DATA_W-1:0]      value_ff;
   logic                                    start_ff;
   logic                                    rsp_valid_ff;
   logic [111:0]                            rsp_data_ff;

   logic                                    req_accept;
   logic [iole_pkg::KIND_W-1:0]             req_kind;
   logic [iole_pkg::POS_W-1:0]              req_pos;
   logic signed [iole_pkg::DATA_W-1:0]      req_value;
   logic [CW-1:0]                           req_pos_ext;
   logic [CW-1:0]                           count_ext;
   logic                                    slot_free;

   iole_pkg::cell_cmd_type                  cmd;
   iole_pkg::sweep_type                     sweep_w [CAPACITY+1];
   logic signed [iole_pkg::DATA_W-1:0]      entry_w [CAPACITY];
   iole_pkg::sweep_type                     last_sweep;

   logic                                    rd_ok;
   logic                                    mm_ok;
   logic                                    is_find;
   logic signed [iole_pkg::DATA_W-1:0]      out_read;
   logic signed [iole_pkg::DATA_W-1:0]      out_min;
   logic signed [iole_pkg::DATA_W-1:0]      out_max;
   logic                                    out_found;
   logic [iole_pkg::FIDX_W-1:0]             out_fidx;

   assign req_kind    = req_tuser;
   assign req_pos     = req_tdata[6:0];
   assign req_value   = req_tdata[38:7];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign req_pos_ext = CW'(req_pos);
   assign count_ext   = CW'(count_ff);
   assign slot_free   = !rsp_valid_ff || rsp_tready;

   // Status and new count are settled when the request word is taken; the
   // cells then shift for a good insert or erase.
   always_comb begin
      status_in = iole_pkg::STATUS_OK;
      count_in  = count_ff;
      op_in     = iole_pkg::SHIFT_NONE;
      case (req_kind)
         iole_pkg::KIND_INSERT: begin
            if (req_pos_ext > count_ext) begin
               status_in = iole_pkg::STATUS_BAD_INDEX;
            end else if (count_ext >= CAP_EXT) begin
               status_in = iole_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
               op_in    = iole_pkg::SHIFT_UP;
            end
         end
         iole_pkg::KIND_ERASE: begin
            if (req_pos_ext >= count_ext) begin
               status_in = iole_pkg::STATUS_BAD_INDEX;
            end else begin
               count_in = count_ff - 1'b1;
               op_in    = iole_pkg::SHIFT_DOWN;
            end
         end
         iole_pkg::KIND_READ: begin
            if (req_pos_ext >= count_ext) begin
               status_in = iole_pkg::STATUS_BAD_INDEX;
            end
         end
         iole_pkg::KIND_MINMAX: begin
            if (count_ff == '0) begin
               status_in = iole_pkg::STATUS_EMPTY;
            end
         end
         default: begin
            status_in = iole_pkg::STATUS_OK;
         end
      endcase
   end

   assign cmd.op       = op_ff;
   assign cmd.position = pos_ff;
   assign cmd.value    = value_ff;

   // The sweep word enters cell zero in the cycle after the request is taken.
   always_comb begin
      sweep_w[0]             = '0;
      sweep_w[0].valid       = start_ff;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      iole_cell #(
         .INDEX    (i),
         .CW       (CW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cmd           (cmd),
         .count_i       (count_ext),
         .left_entry_i  ((i == 0) ? value_ff : entry_w[(i == 0) ? 0 : i - 1]),
         .right_entry_i (entry_w[(i == CAPACITY - 1) ? i : i + 1]),
         .entry_o       (entry_w[i]),
         .sweep_i       (sweep_w[i]),
         .sweep_o       (sweep_w[i+1])
      );
   end

   assign last_sweep = sweep_w[CAPACITY];

   // Fields that do not belong to the request kind read as zero.
   assign rd_ok     = (kind_ff == iole_pkg::KIND_READ) && (status_ff == iole_pkg::STATUS_OK);
   assign mm_ok     = (kind_ff == iole_pkg::KIND_MINMAX) && (status_ff == iole_pkg::STATUS_OK);
   assign is_find   = (kind_ff == iole_pkg::KIND_FIND);
   assign out_read  = rd_ok ? last_sweep.read_value : '0;
   assign out_min   = mm_ok ? last_sweep.minimum : '0;
   assign out_max   = mm_ok ? last_sweep.maximum : '0;
   assign out_found = is_find && last_sweep.found;
   assign out_fidx  = out_found ? last_sweep.found_index : '0;

   // Control state, the held request and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         op_ff        <= iole_pkg::SHIFT_NONE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff    <= req_accept ? op_in : iole_pkg::SHIFT_NONE;
         start_ff <= req_accept;
         // A finished request loads the response slot once it is free.
         if ((state_ff == ST_DONE) && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  kind_ff   <= req_kind;
                  pos_ff    <= req_pos;
                  value_ff  <= req_value;
                  status_ff <= status_in;
                  count_ff  <= count_in;
                  state_ff  <= ST_SWEEP;
               end
            end
            ST_SWEEP: begin
               if (last_sweep.valid) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  rsp_data_ff  <= {iole_pkg::COUNT_W'(count_ext), out_max, out_min, out_fidx,
                                   out_found, out_read, status_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A taken request always starts a sweep on the next cycle.
   `IOLE_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, start_ff && (state_ff == ST_SWEEP))
   // The sweep word leaves the last cell only while the engine waits for it.
   `IOLE_ASSERT_SAME(a_sweep_in_state, clock, reset, last_sweep.valid, state_ff == ST_SWEEP)
   // A good insert grows the list by exactly one entry.
   `IOLE_ASSERT_NEXT(a_insert_grows, clock, reset, req_accept && (op_in == iole_pkg::SHIFT_UP), count_ff == CNTW'($past(count_ff) + 1'b1))
   // The entry count never passes the capacity.
   `IOLE_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ext <= CAP_EXT)

endmodule
